[rtl/core/mtg_pkg.sv]
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 2;
  localparam int IN_DATA_W = 2 * DATA_W;

  localparam int STATE_WORDS_DEF = 624;
  localparam int TAP_OFFSET_DEF = 397;

  localparam logic [16:0] LCG_MUL = 17'd69069;
  localparam int HALF_SHIFT = 16;
  localparam logic [DATA_W-1:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [DATA_W-1:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [DATA_W-1:0] TEMPER_C = 32'hefc60000;

  typedef enum logic [OP_W-1:0] {
    OP_SEED     = 2'd0,
    OP_DRAW     = 2'd1,
    OP_DRAW_MOD = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_A,
    ST_SEED_B,
    ST_TW_PRIME,
    ST_TW_RUN,
    ST_READ,
    ST_TEMPER,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

endpackage

[rtl/core/mtg_ram.sv]
`timescale 1ns / 1ps

module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[rtl/core/mtg_mod.sv]
`timescale 1ns / 1ps

module mtg_mod (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mtg_pkg::div_req_t        req,
  output logic                     done,
  output logic [mtg_pkg::DATA_W-1:0] remainder
);

  import mtg_pkg::*;

  localparam int CW = $clog2(DATA_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [DATA_W-1:0] dq_r;
  logic [DATA_W-1:0] divisor_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_nxt;

  always_comb begin
    rem_sh = {rem_r, dq_r[DATA_W-1]};
    diff = rem_sh - {1'b0, divisor_r};
    rem_nxt = (rem_sh >= {1'b0, divisor_r}) ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(DATA_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r <= req.dividend;
      divisor_r <= req.divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dq_r <= {dq_r[DATA_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign remainder = rem_r;

endmodule

[rtl/core/mersenne_twister_generator.sv]
// Mersenne Twister source of 32-bit pseudo-random words (MT19937 recurrence and tempering).
// The request kind sits in in_tuser: 0 seeds, 1 draws a raw word, 2 draws a word modulo
// range_limit, and 3 is dropped without effect. A seed request fills the word store from the
// 69069 congruential sequence, joining the upper halves of two successive values into each
// word, and then twists the store, giving no result. A draw passes states READ, TEMPER and
// HOLD to its result register; when the read position has reached the end of the store,
// it is first twisted in place, one word per cycle through a RAM with two read ports.
// A modulo draw also passes a restoring divider that retires one quotient bit per cycle. A
// modulo range of zero returns 0 with range_fault set at once and does not advance the
// generator. After reset the store counts as all zeros without any clearing pass, so draws
// return 0 until the first seed. One request is worked on at a time; a finished result may
// wait in the output register while the next request is taken.
`timescale 1ns / 1ps

module mersenne_twister_generator #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF,
  parameter int TAP_OFFSET = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // op
  input  logic [mtg_pkg::OP_W-1:0]      in_tuser,
  // seed_value, range_limit
  input  logic [mtg_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // random_value
  output logic [mtg_pkg::DATA_W-1:0]    out_tdata,
  // range_fault
  output logic [0:0]                    out_tuser
);

  import mtg_pkg::*;

  localparam int AW = $clog2(STATE_WORDS);
  localparam int PW = $clog2(STATE_WORDS + 1);
  localparam int TAP_MOD = TAP_OFFSET % STATE_WORDS;
  localparam logic [PW-1:0] LAST = PW'(STATE_WORDS - 1);
  localparam logic [PW-1:0] FULL = PW'(STATE_WORDS);

  function automatic logic [DATA_W-1:0] temper(input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_fault_r, out_fault_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              zero_r, zero_nxt;
  logic              iss_act_r, iss_act_nxt;
  logic              dv_r, dv_nxt;
  logic              prime_r, prime_nxt;
  logic              draw_r, draw_nxt;
  logic              is_mod_r, is_mod_nxt;
  logic [DATA_W-1:0] range_r, range_nxt;
  logic [DATA_W-1:0] lcg_r, lcg_nxt;
  logic [15:0]       hi_r, hi_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     kd_r, kd_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              fault_r, fault_nxt;
  logic              fwd_a_r, fwd_b_r;
  logic [DATA_W-1:0] fwd_d_r;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [DATA_W-1:0] rd_data_a;
  logic [DATA_W-1:0] rd_data_b;
  logic [DATA_W-1:0] a_fwd;
  logic [DATA_W-1:0] b_fwd;

  logic [DATA_W-1:0] lcg_next;
  logic [PW:0]       tap_sum;
  logic [AW-1:0]     tap_idx;
  logic [AW-1:0]     nxt_idx;
  logic [DATA_W-1:0] y_tw;
  logic [DATA_W-1:0] twist_val;
  logic [DATA_W-1:0] temper_val;
  op_t               in_op;

  div_req_t          div_req;
  logic              div_done;
  logic [DATA_W-1:0] div_rem;

  mtg_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STATE_WORDS)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr_a(rd_addr_a),
    .rd_data_a(rd_data_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_b(rd_data_b)
  );

  mtg_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .remainder(div_rem)
  );

  always_comb begin
    in_op = op_t'(in_tuser);
    lcg_next = lcg_r * {15'd0, LCG_MUL} + 32'd1;
    tap_sum = {1'b0, cnt_r} + (PW + 1)'(TAP_MOD);
    if (tap_sum >= (PW + 1)'(STATE_WORDS)) begin
      tap_sum = tap_sum - (PW + 1)'(STATE_WORDS);
    end
    tap_idx = tap_sum[AW-1:0];
    nxt_idx = (cnt_r == LAST) ? '0 : AW'(cnt_r + PW'(1));
    a_fwd = fwd_a_r ? fwd_d_r : rd_data_a;
    b_fwd = fwd_b_r ? fwd_d_r : rd_data_b;
    y_tw = {cur_r[DATA_W-1], a_fwd[DATA_W-2:0]};
    twist_val = b_fwd ^ (y_tw >> 1) ^ (y_tw[0] ? TWIST_MATRIX : '0);
    temper_val = temper(a_fwd);
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    out_fault_nxt = out_fault_r;
    pos_nxt = pos_r;
    zero_nxt = zero_r;
    iss_act_nxt = iss_act_r;
    dv_nxt = 1'b0;
    prime_nxt = 1'b0;
    draw_nxt = draw_r;
    is_mod_nxt = is_mod_r;
    range_nxt = range_r;
    lcg_nxt = lcg_r;
    hi_nxt = hi_r;
    cnt_nxt = cnt_r;
    kd_nxt = kd_r;
    cur_nxt = cur_r;
    res_nxt = res_r;
    fault_nxt = fault_r;
    wr_en = 1'b0;
    wr_addr = kd_r;
    wr_data = twist_val;
    rd_addr_a = '0;
    rd_addr_b = '0;
    in_tready = 1'b0;
    div_req.start = 1'b0;
    div_req.dividend = temper_val;
    div_req.divisor = range_r;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_op) inside
            OP_SEED: begin
              lcg_nxt = in_tdata[DATA_W-1:0];
              cnt_nxt = '0;
              zero_nxt = 1'b0;
              draw_nxt = 1'b0;
              state_nxt = ST_SEED_A;
            end
            OP_DRAW, OP_DRAW_MOD: begin
              is_mod_nxt = (in_op == OP_DRAW_MOD);
              range_nxt = in_tdata[IN_DATA_W-1:DATA_W];
              draw_nxt = 1'b1;
              fault_nxt = 1'b0;
              if (in_op == OP_DRAW_MOD && in_tdata[IN_DATA_W-1:DATA_W] == '0) begin
                res_nxt = '0;
                fault_nxt = 1'b1;
                state_nxt = ST_HOLD;
              end else if (zero_r) begin
                res_nxt = '0;
                state_nxt = ST_HOLD;
              end else if (pos_r == FULL) begin
                state_nxt = ST_TW_PRIME;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEED_A: begin
        lcg_nxt = lcg_next;
        hi_nxt = lcg_next[DATA_W-1:HALF_SHIFT];
        state_nxt = ST_SEED_B;
      end
      ST_SEED_B: begin
        lcg_nxt = lcg_next;
        wr_en = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = {hi_r, lcg_next[DATA_W-1:HALF_SHIFT]};
        if (cnt_r == LAST) begin
          state_nxt = ST_TW_PRIME;
        end else begin
          cnt_nxt = cnt_r + PW'(1);
          state_nxt = ST_SEED_A;
        end
      end
      ST_TW_PRIME: begin
        rd_addr_a = '0;
        cnt_nxt = '0;
        iss_act_nxt = 1'b1;
        prime_nxt = 1'b1;
        state_nxt = ST_TW_RUN;
      end
      ST_TW_RUN: begin
        if (iss_act_r) begin
          rd_addr_a = nxt_idx;
          rd_addr_b = tap_idx;
          dv_nxt = 1'b1;
          kd_nxt = cnt_r[AW-1:0];
          if (cnt_r == LAST) begin
            iss_act_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + PW'(1);
          end
        end
        if (prime_r) begin
          cur_nxt = a_fwd;
        end
        if (dv_r) begin
          wr_en = 1'b1;
          wr_addr = kd_r;
          wr_data = twist_val;
          cur_nxt = a_fwd;
          if (kd_r == AW'(STATE_WORDS - 1)) begin
            pos_nxt = '0;
            state_nxt = draw_r ? ST_READ : ST_IDLE;
          end
        end
      end
      ST_READ: begin
        rd_addr_a = pos_r[AW-1:0];
        pos_nxt = pos_r + PW'(1);
        state_nxt = ST_TEMPER;
      end
      ST_TEMPER: begin
        if (is_mod_r) begin
          div_req.start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          res_nxt = temper_val;
          state_nxt = ST_HOLD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt = div_rem;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          out_fault_nxt = fault_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r <= FULL;
      zero_r <= 1'b1;
      iss_act_r <= 1'b0;
      dv_r <= 1'b0;
      prime_r <= 1'b0;
      draw_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r <= pos_nxt;
      zero_r <= zero_nxt;
      iss_act_r <= iss_act_nxt;
      dv_r <= dv_nxt;
      prime_r <= prime_nxt;
      draw_r <= draw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_fault_r <= out_fault_nxt;
    is_mod_r <= is_mod_nxt;
    range_r <= range_nxt;
    lcg_r <= lcg_nxt;
    hi_r <= hi_nxt;
    cnt_r <= cnt_nxt;
    kd_r <= kd_nxt;
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    fault_r <= fault_nxt;
    fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
    fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
    fwd_d_r <= wr_data;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_fault_r;

endmodule

[rtl/core/mtg_checker.sv]
`timescale 1ns / 1ps

module mtg_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [mtg_pkg::OP_W-1:0]      in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mtg_pkg::DATA_W-1:0]    out_tdata,
  input logic [0:0]                    out_tuser
);

  import mtg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("Range fault with a nonzero value.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Block not idle after reset.");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_SEED |=> !in_tready)
    else $error("Request taken during seeding.");

  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_SEED && in_tuser != OP_DRAW &&
    in_tuser != OP_DRAW_MOD |=> in_tready)
    else $error("Unused request kind stalled the block.");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);
